// ===== hw/rtl/cgnd_pkg.sv =====
package cgnd_pkg;

    // input op codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_RETIRE = 2'd2;

    // configuration register indexes
    localparam logic CFG_VECTOR_LENGTH = 1'b0;
    localparam logic CFG_BUDGET        = 1'b1;

    localparam int CFG_DW   = 8;
    localparam int OP_W     = 2;
    localparam int TRACK_W  = 5;
    localparam int VALUE_W  = 16;
    localparam int DIST_W   = 16;
    localparam int BUDGET_W = 5;
    localparam int S_DATA_W = 24;

    localparam logic [DIST_W-1:0] DIST_EMPTY = 16'hFFFF;
    localparam logic [DIST_W-1:0] ONE_Q14    = 16'd16384;
    localparam int FRAC_SHIFT = 22;
    localparam int NORM_SHIFT = 8;

    typedef struct packed {
        logic load;
        logic g_we;
        logic q_we;
        logic rd;
        logic acc_clear;
        logic sqrt_start;
        logic den_load;
        logic div_start;
        logic best_init;
        logic best_update;
        logic out_load;
        logic out_empty;
    } cmd_t;

    typedef struct packed {
        logic acc_busy;
        logic sqrt_busy;
        logic div_busy;
    } sts_t;

endpackage

// ===== hw/rtl/cgnd_sqrt.sv =====
module cgnd_sqrt #(
    parameter int XW = 46
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [XW-1:0]   x,
    output logic            busy,
    output logic [XW/2-1:0] root
);
    logic [XW-1:0] x_reg;
    logic [XW-1:0] r_reg;
    logic [XW-1:0] bit_reg;
    logic          busy_reg;
    logic [XW-1:0] trial;

    assign trial = r_reg + bit_reg;
    assign busy  = busy_reg;
    assign root  = r_reg[XW/2-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
        end
    end

    // one result bit per cycle, digit by digit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            r_reg   <= '0;
            bit_reg <= XW'(1) << (XW - 2);
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end
endmodule

// ===== hw/rtl/cgnd_div.sv =====
module cgnd_div #(
    parameter int NW = 61,
    parameter int DW = 46
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   n_reg;
    logic [DW-1:0]   d_reg;
    logic [DW-1:0]   rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic [DW:0]     trial;
    logic            fits;

    assign trial = {rem_reg, n_reg[NW-1]};
    assign fits  = trial >= {1'b0, d_reg};
    assign busy  = busy_reg;
    assign quo   = n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // restoring division, quotient shifts into the numerator register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num;
            d_reg   <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, d_reg}) : trial[DW-1:0];
            n_reg   <= {n_reg[NW-2:0], fits};
        end
    end
endmodule

// ===== hw/rtl/cgnd_dp.sv =====
module cgnd_dp #(
    parameter int TRACKS     = 32,
    parameter int MAX_BUDGET = 16,
    parameter int MAX_DIM    = 128,
    parameter int TW         = 5,
    parameter int SW         = 4,
    parameter int IW         = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cgnd_pkg::cmd_t                cmd,
    output cgnd_pkg::sts_t                sts,
    input  logic [TW-1:0]                 track,
    input  logic [SW-1:0]                 slot,
    input  logic [IW-1:0]                 idx,
    input  logic [cgnd_pkg::VALUE_W-1:0]  in_value,
    output logic [cgnd_pkg::DIST_W-1:0]   dist_out,
    output logic                          empty
);
    import cgnd_pkg::*;

    localparam int GDEPTH = TRACKS * MAX_BUDGET * MAX_DIM;
    localparam int AW     = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int UW     = 31 + $clog2(MAX_DIM);
    localparam int SDW    = UW + 1;
    localparam int XW0    = UW + NORM_SHIFT;
    localparam int XW     = XW0 + (XW0 % 2);
    localparam int RW     = XW / 2;
    localparam int DENW   = 2 * RW;
    localparam int NUMW   = UW + FRAC_SHIFT + 1;

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] gmem [GDEPTH];
    logic [VALUE_W-1:0] qmem [MAX_DIM];
    logic [VALUE_W-1:0] g_q_reg;
    logic [VALUE_W-1:0] q_q_reg;
    logic [AW-1:0]      gaddr;

    logic               v1_reg;
    logic               v2_reg;
    logic signed [31:0] p_dot_reg;
    logic [31:0]        p_uu_reg;
    logic [31:0]        p_vv_reg;
    logic signed [SDW-1:0] dot_reg;
    logic [UW-1:0]      nu_reg;
    logic [UW-1:0]      nv_reg;

    logic [RW-1:0]      su;
    logic [RW-1:0]      sv;
    logic               su_busy;
    logic               sv_busy;
    logic [DENW-1:0]    den_reg;
    logic [SDW-1:0]     mag_full;
    logic [NUMW-1:0]    num;
    logic [NUMW-1:0]    quo;
    logic               div_busy;
    logic [14:0]        m;
    logic [DIST_W-1:0]  d;
    logic [DIST_W-1:0]  best_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               empty_reg;

    assign gaddr = AW'((32'(track) * 32'(MAX_BUDGET) + 32'(slot)) * 32'(MAX_DIM) + 32'(idx));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= in_value;
        end
        if (cmd.g_we)
        begin
            gmem[gaddr] <= value_reg;
        end
        if (cmd.rd)
        begin
            g_q_reg <= gmem[gaddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_we)
        begin
            qmem[idx] <= value_reg;
        end
        if (cmd.rd)
        begin
            q_q_reg <= qmem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd;
            v2_reg <= v1_reg;
        end
    end

    // products, then accumulation
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            p_dot_reg <= $signed(q_q_reg) * $signed(g_q_reg);
            p_uu_reg  <= 32'($signed(q_q_reg) * $signed(q_q_reg));
            p_vv_reg  <= 32'($signed(g_q_reg) * $signed(g_q_reg));
        end
        if (cmd.acc_clear)
        begin
            dot_reg <= '0;
            nu_reg  <= '0;
            nv_reg  <= '0;
        end
        else if (v2_reg)
        begin
            dot_reg <= dot_reg + SDW'(p_dot_reg);
            nu_reg  <= nu_reg + UW'(p_uu_reg);
            nv_reg  <= nv_reg + UW'(p_vv_reg);
        end
    end

    cgnd_sqrt #(.XW(XW)) u_sqrt_u (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .x     (XW'({nu_reg, NORM_SHIFT'(0)})),
        .busy  (su_busy),
        .root  (su)
    );

    cgnd_sqrt #(.XW(XW)) u_sqrt_v (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .x     (XW'({nv_reg, NORM_SHIFT'(0)})),
        .busy  (sv_busy),
        .root  (sv)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.den_load)
        begin
            den_reg <= su * sv;
        end
    end

    assign mag_full = dot_reg[SDW-1] ? SDW'(-dot_reg) : SDW'(dot_reg);
    assign num      = NUMW'({mag_full[UW-1:0], FRAC_SHIFT'(0)}) + NUMW'(den_reg >> 1);

    cgnd_div #(.NW(NUMW), .DW(DENW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_comb
    begin
        m = (quo > NUMW'(ONE_Q14)) ? ONE_Q14[14:0] : quo[14:0];
        if (nu_reg == '0 || nv_reg == '0)
        begin
            d = '0;
        end
        else if (dot_reg[SDW-1])
        begin
            d = ONE_Q14 + DIST_W'(m);
        end
        else
        begin
            d = ONE_Q14 - DIST_W'(m);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.best_init)
        begin
            best_reg <= DIST_EMPTY;
        end
        else if (cmd.best_update && d < best_reg)
        begin
            best_reg <= d;
        end
        if (cmd.out_load)
        begin
            dist_reg  <= cmd.out_empty ? DIST_EMPTY : best_reg;
            empty_reg <= cmd.out_empty;
        end
    end

    assign dist_out      = dist_reg;
    assign empty         = empty_reg;
    assign sts.acc_busy  = v1_reg | v2_reg;
    assign sts.sqrt_busy = su_busy | sv_busy;
    assign sts.div_busy  = div_busy;
endmodule

// ===== hw/rtl/cgnd_ctrl.sv =====
module cgnd_ctrl #(
    parameter int TRACKS     = 32,
    parameter int MAX_BUDGET = 16,
    parameter int MAX_DIM    = 128,
    parameter int TW         = 5,
    parameter int SW         = 4,
    parameter int IW         = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cgnd_pkg::OP_W-1:0]     s_op,
    input  logic [cgnd_pkg::TRACK_W-1:0]  s_track,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [cgnd_pkg::CFG_DW-1:0]   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output cgnd_pkg::cmd_t                cmd,
    input  cgnd_pkg::sts_t                sts,
    output logic [TW-1:0]                 track,
    output logic [SW-1:0]                 slot,
    output logic [IW-1:0]                 idx
);
    import cgnd_pkg::*;

    localparam int CW  = $clog2(MAX_BUDGET + 1);
    localparam int BW  = (CW > BUDGET_W) ? CW : BUDGET_W;
    localparam int LW  = $clog2(MAX_DIM + 1);
    localparam int LCW = (LW > CFG_DW) ? LW : CFG_DW;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_REDUCE = 4'd1;
    localparam logic [3:0] ST_EXEC   = 4'd2;
    localparam logic [3:0] ST_READ   = 4'd3;
    localparam logic [3:0] ST_DRAIN  = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_DEN    = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_BEST   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;
    localparam logic [3:0] ST_DSTART = 4'd10;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [CFG_DW-1:0]   vlen_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic [IW-1:0]       ei_reg;
    logic [CW-1:0]       cnt_tab [TRACKS];
    logic [SW-1:0]       old_tab [TRACKS];
    logic [TW-1:0]       trk_map [32];
    logic [OP_W-1:0]     op_reg;
    logic [TW-1:0]       trk_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       old_reg;
    logic [CW-1:0]       k_reg;
    logic [CW-1:0]       slot_reg;
    logic [IW-1:0]       i_reg;
    logic                empty_reg;
    logic                mval_reg;

    logic [CW-1:0]       eff_b;
    logic [LW-1:0]       eff_len;
    logic [LW-1:0]       len_m1;
    logic                last;
    logic [IW-1:0]       cur_idx;
    logic [CW:0]         ring_sum;
    logic [CW-1:0]       wslot;
    logic [CW-1:0]       old_inc;
    logic [CW-1:0]       slot_inc;
    logic [CW-1:0]       tab_cnt;
    logic                accept;
    logic                out_free;

    // track number folded onto the table size
    for (genvar g = 0; g < 32; g++)
    begin : g_trk
        assign trk_map[g] = TW'(g % TRACKS);
    end

    always_comb
    begin
        if (budget_reg == '0)
        begin
            eff_b = CW'(1);
        end
        else if (BW'(budget_reg) > BW'(MAX_BUDGET))
        begin
            eff_b = CW'(MAX_BUDGET);
        end
        else
        begin
            eff_b = CW'(budget_reg);
        end
        if (vlen_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (LCW'(vlen_reg) > LCW'(MAX_DIM))
        begin
            eff_len = LW'(MAX_DIM);
        end
        else
        begin
            eff_len = LW'(vlen_reg);
        end
    end

    assign len_m1   = eff_len - 1'b1;
    assign last     = LW'(ei_reg) >= len_m1;
    assign cur_idx  = last ? IW'(len_m1) : ei_reg;
    assign ring_sum = {1'b0, old_reg} + {1'b0, cnt_reg};
    assign wslot    = (cnt_reg < eff_b) ?
                      ((ring_sum >= {1'b0, eff_b}) ? CW'(ring_sum - {1'b0, eff_b})
                                                   : CW'(ring_sum))
                      : old_reg;
    assign old_inc  = (old_reg + 1'b1 == eff_b) ? '0 : old_reg + 1'b1;
    assign slot_inc = (slot_reg + 1'b1 == eff_b) ? '0 : slot_reg + 1'b1;
    assign tab_cnt  = cnt_tab[trk_map[s_track]];
    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !mval_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign track    = trk_reg;
    assign slot     = (state_reg == ST_EXEC) ? SW'(wslot) : SW'(slot_reg);
    assign idx      = (state_reg == ST_EXEC) ? cur_idx : i_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (old_reg < eff_b)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                cmd.g_we   = (op_reg == OP_APPEND);
                cmd.q_we   = (op_reg == OP_QUERY);
                if (op_reg == OP_QUERY && last)
                begin
                    cmd.best_init = 1'b1;
                    state_next    = (cnt_reg == '0) ? ST_OUT : ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd        = 1'b1;
                cmd.acc_clear = (i_reg == '0);
                if (LW'(i_reg) == len_m1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.acc_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (!sts.sqrt_busy)
                begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                cmd.den_load = 1'b1;
                state_next   = ST_DSTART;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_BEST;
                end
            end
            ST_BEST:
            begin
                cmd.best_update = 1'b1;
                state_next      = (k_reg + 1'b1 == cnt_reg) ? ST_OUT : ST_READ;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_empty = empty_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vlen_reg   <= CFG_DW'(MAX_DIM > 255 ? 128 : 128);
            budget_reg <= BUDGET_W'(16);
            ei_reg     <= '0;
            mval_reg   <= 1'b0;
            for (int n = 0; n < TRACKS; n++)
            begin
                cnt_tab[n] <= '0;
                old_tab[n] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == CFG_VECTOR_LENGTH)
            begin
                vlen_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_BUDGET)
            begin
                budget_reg <= cfg_data[BUDGET_W-1:0];
            end
            if (cmd.out_load)
            begin
                mval_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mval_reg <= 1'b0;
            end
            if (state_reg == ST_EXEC)
            begin
                priority case (op_reg)
                    OP_RETIRE:
                    begin
                        cnt_tab[trk_reg] <= '0;
                        old_tab[trk_reg] <= '0;
                        ei_reg           <= '0;
                    end
                    OP_APPEND:
                    begin
                        ei_reg <= last ? '0 : cur_idx + 1'b1;
                        if (last && cnt_reg < eff_b)
                        begin
                            cnt_tab[trk_reg] <= cnt_reg + 1'b1;
                            old_tab[trk_reg] <= SW'(old_reg);
                        end
                        else if (last)
                        begin
                            cnt_tab[trk_reg] <= eff_b;
                            old_tab[trk_reg] <= SW'(old_inc);
                        end
                    end
                    OP_QUERY:
                    begin
                        ei_reg <= last ? '0 : cur_idx + 1'b1;
                    end
                    default:
                    begin
                        ei_reg <= ei_reg;
                    end
                endcase
            end
        end
    end

    // item fields and sample loop counters
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_op;
            trk_reg <= trk_map[s_track];
            cnt_reg <= (tab_cnt > eff_b) ? eff_b : tab_cnt;
            old_reg <= CW'(old_tab[trk_map[s_track]]);
        end
        else if (state_reg == ST_REDUCE && old_reg >= eff_b)
        begin
            old_reg <= old_reg - eff_b;
        end
        if (state_reg == ST_EXEC)
        begin
            k_reg     <= '0;
            slot_reg  <= old_reg;
            i_reg     <= '0;
            empty_reg <= (cnt_reg == '0);
        end
        else if (state_reg == ST_READ)
        begin
            i_reg <= i_reg + 1'b1;
        end
        else if (state_reg == ST_BEST)
        begin
            k_reg    <= k_reg + 1'b1;
            slot_reg <= slot_inc;
            i_reg    <= '0;
        end
    end
endmodule

// ===== hw/rtl/cosine_gallery_nearest_distance.sv =====
// cosine nearest-neighbor gallery: each track keeps a ring of up to budget feature
// vectors that arrive one signed Q1.15 element per transfer (op 0 append, op 1 query,
// op 2 retire track). when the last query element lands, the block returns the
// smallest cosine distance to the track's stored samples in Q2.14 (16384 = 1.0), or
// 65535 with empty_gallery set when the track holds nothing. append, retire and
// non-final query elements pass the reduce and execute states, staying in reduce once
// more per ring wrap the oldest-slot pointer needs after budget was lowered. a final
// query element then handles each of the cnt stored samples in turn, with len the
// vector length, rw = ceil((39 + clog2(MAX_DIM)) / 2) square-root steps and nw =
// 54 + clog2(MAX_DIM) divide steps (23 and 61 at the default size); each sample streams
// len elements through the single gallery memory read port into the product registers
// and accumulators, then runs two bit-serial square roots and a bit-serial divider.
// the result sits in an output register, so a new transfer is taken while it waits.
// the user must write configuration only while the block is idle; it is not enforced.
module cosine_gallery_nearest_distance #(
    parameter int TRACKS     = 32,
    parameter int MAX_BUDGET = 16,
    parameter int MAX_DIM    = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[1:0], track[6:2], value[22:7], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // distance[15:0]
    output logic        m_tuser,   // empty_gallery
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import cgnd_pkg::*;

    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int SW = (MAX_BUDGET > 1) ? $clog2(MAX_BUDGET) : 1;
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    cmd_t           cmd;
    sts_t           sts;
    logic [TW-1:0]  track;
    logic [SW-1:0]  slot;
    logic [IW-1:0]  idx;

    // controller: handshake, registers, per-track ring state and the sample loop
    cgnd_ctrl #(
        .TRACKS     (TRACKS),
        .MAX_BUDGET (MAX_BUDGET),
        .MAX_DIM    (MAX_DIM),
        .TW         (TW),
        .SW         (SW),
        .IW         (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_tdata[1:0]),
        .s_track   (s_tdata[6:2]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .track     (track),
        .slot      (slot),
        .idx       (idx)
    );

    // datapath: gallery and query memories, accumulators, sqrt, divide, minimum
    cgnd_dp #(
        .TRACKS     (TRACKS),
        .MAX_BUDGET (MAX_BUDGET),
        .MAX_DIM    (MAX_DIM),
        .TW         (TW),
        .SW         (SW),
        .IW         (IW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .track    (track),
        .slot     (slot),
        .idx      (idx),
        .in_value (s_tdata[22:7]),
        .dist_out (m_tdata),
        .empty    (m_tuser)
    );
endmodule

// ===== hw/rtl/cgnd_checker.sv =====
module cgnd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);
    // one item at a time: a transfer in is never followed at once by another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous item still in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'hFFFF)
        else $error("empty gallery result without empty code");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata <= 16'd32768)
        else $error("distance above 2.0");
endmodule

bind cosine_gallery_nearest_distance cgnd_checker u_chk (.*);

// ===== tb/tb_cosine_gallery_nearest_distance.sv =====
module tb_cosine_gallery_nearest_distance;
    import cgnd_pkg::*;

    // op code that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int N_TRACKS = 32;
    localparam int N_SLOTS = 16;
    localparam int N_DIM = 128;
    // settle time after the last result before a register write or the end of the run
    localparam int SETTLE_CYCLES = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [15:0] distance;
        logic        empty_gallery;
    } gallery_result_t;

    // predicts the nearest-sample distance and holds the results still to come
    class nearest_scoreboard;
        bit [15:0] gallery [N_TRACKS][N_SLOTS][N_DIM];
        bit        gallery_set [N_TRACKS][N_SLOTS][N_DIM];
        bit [15:0] query_vec [N_DIM];
        bit        query_set [N_DIM];
        int unsigned sample_cnt [N_TRACKS];
        int unsigned oldest [N_TRACKS];
        int unsigned elem_idx;
        int unsigned vec_len;
        int unsigned ring_size;
        gallery_result_t pending_results [$];
        int errors;

        function new();
            foreach (sample_cnt[t])
            begin
                sample_cnt[t] = 0;
                oldest[t] = 0;
            end
            elem_idx = 0;
            vec_len = 128;
            ring_size = 16;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] data);
            if (idx == CFG_VECTOR_LENGTH)
                vec_len = data;
            else
                ring_size = data[4:0];
        endfunction

        function int unsigned len_eff();
            if (vec_len == 0)
                return 1;
            return (vec_len > N_DIM) ? N_DIM : vec_len;
        endfunction

        function int unsigned ring_eff();
            if (ring_size == 0)
                return 1;
            return (ring_size > N_SLOTS) ? N_SLOTS : ring_size;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned root;
            longint unsigned one;
            root = 0;
            one = 64'd1 << 62;
            while (one > x)
                one >>= 2;
            while (one != 0)
            begin
                if (x >= root + one)
                begin
                    x -= root + one;
                    root = (root >> 1) + one;
                end
                else
                    root >>= 1;
                one >>= 2;
            end
            return root;
        endfunction

        // cosine distance between the query buffer and one stored sample, Q2.14
        function int unsigned cos_distance(int unsigned trk, int unsigned slot);
            longint dot;
            longint a;
            longint b;
            longint unsigned nq;
            longint unsigned ns;
            longint unsigned den;
            longint unsigned mag;
            longint unsigned m;
            dot = 0;
            nq = 0;
            ns = 0;
            for (int i = 0; i < len_eff(); i++)
            begin
                a = $signed(query_vec[i]);
                b = $signed(gallery[trk][slot][i]);
                dot += a * b;
                nq += a * a;
                ns += b * b;
            end
            if (nq == 0 || ns == 0)
                return 0;
            den = int_sqrt(nq << 8) * int_sqrt(ns << 8);
            mag = (dot < 0) ? -dot : dot;
            m = ((mag << 22) + den / 2) / den;
            if (m > 16384)
                m = 16384;
            return 32'((dot < 0) ? 16384 + m : 16384 - m);
        endfunction

        // true when this query element would close a vector that touches storage
        // that was never written
        function bit query_reads_unwritten(logic [4:0] trk);
            int unsigned idx;
            int unsigned cnt;
            int unsigned old;
            idx = (elem_idx >= len_eff()) ? len_eff() - 1 : elem_idx;
            if (idx != len_eff() - 1)
                return 0;
            cnt = (sample_cnt[trk] > ring_eff()) ? ring_eff() : sample_cnt[trk];
            old = oldest[trk] % ring_eff();
            for (int i = 0; i < len_eff(); i++)
            begin
                if (i != idx && !query_set[i])
                    return 1;
                for (int k = 0; k < cnt; k++)
                    if (!gallery_set[trk][(old + k) % ring_eff()][i])
                        return 1;
            end
            return 0;
        endfunction

        function void note_transfer(logic [1:0] op, logic [4:0] trk, logic [15:0] val);
            int unsigned len;
            int unsigned rs;
            int unsigned idx;
            int unsigned cnt;
            int unsigned old;
            int unsigned slot;
            int unsigned best;
            int unsigned d;
            bit last;
            gallery_result_t res;
            len = len_eff();
            rs = ring_eff();
            idx = (elem_idx >= len) ? len - 1 : elem_idx;
            last = (idx == len - 1);
            cnt = (sample_cnt[trk] > rs) ? rs : sample_cnt[trk];
            old = oldest[trk] % rs;
            if (op == OP_RETIRE)
            begin
                sample_cnt[trk] = 0;
                oldest[trk] = 0;
                elem_idx = 0;
                return;
            end
            if (op == OP_UNUSED)
                return;
            elem_idx = last ? 0 : idx + 1;
            if (op == OP_APPEND)
            begin
                slot = (cnt < rs) ? (old + cnt) % rs : old;
                gallery[trk][slot][idx] = val;
                gallery_set[trk][slot][idx] = 1;
                if (last)
                begin
                    if (cnt < rs)
                    begin
                        sample_cnt[trk] = cnt + 1;
                        oldest[trk] = old;
                    end
                    else
                    begin
                        sample_cnt[trk] = rs;
                        oldest[trk] = (old + 1) % rs;
                    end
                end
                return;
            end
            query_vec[idx] = val;
            query_set[idx] = 1;
            if (!last)
                return;
            if (cnt == 0)
            begin
                res.distance = DIST_EMPTY;
                res.empty_gallery = 1'b1;
            end
            else
            begin
                best = 65535;
                for (int k = 0; k < cnt; k++)
                begin
                    d = cos_distance(trk, (old + k) % rs);
                    if (d < best)
                        best = d;
                end
                res.distance = 16'(best);
                res.empty_gallery = 1'b0;
            end
            pending_results.insert(pending_results.size(), res);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [15:0] got_dist, logic empty);
            gallery_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result distance=%0d empty=%0b", got_dist, empty));
                return;
            end
            want = pending_results.pop_front();
            if (got_dist !== want.distance)
                report($sformatf("distance got %0d want %0d", got_dist, want.distance));
            if (empty !== want.empty_gallery)
                report($sformatf("empty_gallery got %0b want %0b", empty, want.empty_gallery));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // op[1:0], track[6:2], value[22:7], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // distance[15:0]
    logic        m_tuser;   // empty_gallery
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    nearest_scoreboard sb;
    // no random idling on either side while set
    bit steady;
    longint cycles;
    logic [15:0] pattern [N_DIM];

    cosine_gallery_nearest_distance DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side: random back-pressure, check every accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // one input transfer; a query that would close on unwritten storage turns into an append
    task automatic send(logic [1:0] op, logic [4:0] trk, logic [15:0] val);
        if (op == OP_QUERY && sb.query_reads_unwritten(trk))
            op = OP_APPEND;
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, val, trk, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_transfer(op, trk, val);
    endtask

    // drain all results, then give the block time to finish item work with no result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // element value for one vector, by pattern kind
    function automatic logic [15:0] pick_value(int kind, int i);
        case (kind)
            0: return 16'h0000;
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            3: return pattern[i];
            4: return -pattern[i];
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_vector(logic [1:0] op, logic [4:0] trk, int kind);
        for (int i = 0; i < sb.len_eff(); i++)
            send(op, trk, pick_value(kind, i));
    endtask

    int lens [10] = '{4, 1, 0, 3, 7, 2, 128, 200, 6, 255};
    int rings [10] = '{2, 1, 0, 16, 31, 5, 16, 3, 1, 4};

    initial
    begin
        int budget_items;
        int sent;
        logic [1:0] op;
        logic [4:0] trk;
        sb = new();
        steady = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        foreach (pattern[i])
            pattern[i] = 16'($urandom());
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: length 4, ring of 2
        write_cfg(CFG_VECTOR_LENGTH, 8'd4);
        write_cfg(CFG_BUDGET, 8'd2);
        // empty gallery query with extreme elements
        send(OP_QUERY, 5'd0, 16'h8000);
        send(OP_QUERY, 5'd0, 16'h7FFF);
        send(OP_QUERY, 5'd0, 16'h0000);
        send(OP_QUERY, 5'd0, 16'h0001);
        // identical and opposite query against one stored sample
        send_vector(OP_APPEND, 5'd31, 3);
        send_vector(OP_QUERY, 5'd31, 3);
        send_vector(OP_QUERY, 5'd31, 4);
        // ignored op, then a retire that drops a partial vector
        send(OP_UNUSED, 5'd31, 16'hFFFF);
        send(OP_APPEND, 5'd31, 16'h1234);
        send(OP_RETIRE, 5'd31, 16'h0000);
        send_vector(OP_QUERY, 5'd31, 0);
        settle();

        foreach (lens[p])
        begin
            write_cfg(CFG_VECTOR_LENGTH, 8'(lens[p]));
            write_cfg(CFG_BUDGET, 8'(rings[p]));
            foreach (pattern[i])
                pattern[i] = 16'($urandom());
            steady = (p == 3);
            budget_items = 80;
            sent = 0;
            while (sent < budget_items)
            begin
                trk = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 2));
                if ($urandom_range(0, 99) < 82)
                begin
                    // well-formed vector, appends more often so rings fill and wrap
                    op = ($urandom_range(0, 99) < 60) ? OP_APPEND : OP_QUERY;
                    send_vector(op, trk, $urandom_range(0, 5));
                    sent += sb.len_eff();
                end
                else
                begin
                    // noise: any op, any track, including retire and the ignored op
                    send(2'($urandom()), trk, 16'($urandom()));
                    sent++;
                end
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
